@@ hw/rtl/ncu_pkg.sv @@
// ----------------------------------------------------------------------------
// ncu_pkg: shared types and constants of the nibble coefficient unpacker
// Item codes, parse phases, run kinds, fixed-point constants and the
// quantizer scaling function used by the parser and the noise unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ncu_pkg;

  localparam int MAX_SUBBLOCK   = 8192;
  localparam int COEF_FRAC_BITS = 36;

  localparam int LEN_W   = 14;
  localparam int COEF_W  = 40;
  localparam int DECAY_W = 17;

  localparam logic [COEF_W-1:0]  MAG_MAX         = 40'h7F_FFFF_FFFF;
  localparam logic [DECAY_W-1:0] DECAY_ONE       = 17'h1_0000;
  localparam logic [31:0]        NOISE_SEED_INIT = 32'd1234567;

  // Item kinds on the input channel.
  localparam logic [1:0] FN_START  = 2'd0;
  localparam logic [1:0] FN_NIBBLE = 2'd1;
  localparam logic [1:0] FN_PULL   = 2'd2;

  // Special nibble codes.
  localparam logic [3:0] NIB_ESC_Q   = 4'hE;
  localparam logic [3:0] NIB_FILL    = 4'hF;
  localparam logic [3:0] NIB_ESC_RUN = 4'h8;
  localparam logic [3:0] NIB_ESC_Z   = 4'h0;
  localparam logic [3:0] NIB_EXT_MAX = 4'd12;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_Q1   = 4'd1,
    PH_Q1E  = 4'd2,
    PH_COEF = 4'd3,
    PH_Z1   = 4'd4,
    PH_Z2   = 4'd5,
    PH_Z3   = 4'd6,
    PH_E1   = 4'd7,
    PH_QC   = 4'd8,
    PH_QCE  = 4'd9,
    PH_NFV  = 4'd10,
    PH_NFS  = 4'd11,
    PH_NFH  = 4'd12,
    PH_NFL  = 4'd13,
    PH_RUN  = 4'd14
  } ph_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ZERO  = 2'd1,
    KIND_NOISE = 2'd2
  } kind_t;

  // Commands from the parser to the noise unit.
  typedef struct packed {
    logic               step;
    logic               load_amp;
    logic [5:0]         amp_mult;
    logic               load_decay;
    logic [DECAY_W-1:0] decay;
    logic [4:0]         quant;
  } noise_ctl_t;

  // Result of one item as seen by the parser.
  typedef struct packed {
    logic              noise_sel;
    logic [COEF_W-1:0] coef;
    logic              coef_valid;
    logic              want_nibble;
    logic              done;
    logic              err;
  } res_t;

  // mult times the quantizer step 2^-(5+q), in units of 2^-COEF_FRAC_BITS,
  // saturated to the largest magnitude.
  function automatic logic [COEF_W-1:0] scaled(input logic [5:0] mult,
                                               input logic [4:0] q);
    int          sh;
    logic [63:0] m;
    sh = COEF_FRAC_BITS - 5 - int'(q);
    if (sh < 0) sh = 0;
    if (sh > 50) sh = 50;
    m = {58'b0, mult} << sh;
    if (m > {24'b0, MAG_MAX}) return MAG_MAX;
    return m[COEF_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nibble_coefficient_unpacker.sv @@
// ----------------------------------------------------------------------------
// nibble_coefficient_unpacker: top level
// Decodes one sub-block of nibble-coded coefficients into 40-bit signed
// fixed-point values (scale 2^-36), one result for every input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_func selects start (with
//   in_subblock_length), nibble (with in_nibble) or pull of a pending run.
//   Output channel (out_valid / out_stall): exactly one result per input
//   transfer, in order: out_coefficient with out_coef_valid, out_want_nibble
//   telling the source whether to send a nibble or a pull next,
//   out_subblock_done on the last coefficient, and out_error_flag.
//   Pipeline: an item waits in the input register after its input transfer,
//   and the decoder state is updated as it moves into the result register,
//   from which its result is presented on the output.
//   Throughput: one item per cycle, sustained, as long as the output is not
//   stalled. The noise path is one multiplier between the noise registers
//   and the result register.
//   Stall: while out_stall holds a result, it stays unchanged; one more item
//   can wait in the input register, after which in_stall rises.
//   Reset (rst_n low, synchronous): both registers empty, the parser idle
//   waiting for a start item, quantizer zero, noise seed back to 1234567.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_coefficient_unpacker
  import ncu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_func,
  input  wire logic [3:0]        in_nibble,
  input  wire logic [LEN_W-1:0]  in_subblock_length,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic                   out_coef_valid,
  output logic                   out_want_nibble,
  output logic                   out_subblock_done,
  output logic                   out_error_flag
);

  logic             s1_valid_r;
  logic [1:0]       s1_func_r;
  logic [3:0]       s1_nibble_r;
  logic [LEN_W-1:0] s1_len_r;

  logic              out_valid_r;
  logic [COEF_W-1:0] out_coef_r;
  logic              out_coef_valid_r;
  logic              out_want_r;
  logic              out_done_r;
  logic              out_err_r;

  logic              adv;
  logic              fire;
  logic              in_take;
  noise_ctl_t        ctl;
  res_t              res;
  logic [COEF_W-1:0] noise_coef;
  logic [COEF_W-1:0] coef_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r   <= in_func;
      s1_nibble_r <= in_nibble;
      s1_len_r    <= in_subblock_length;
    end
  end

  ncu_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item_func   (s1_func_r),
    .item_nibble (s1_nibble_r),
    .item_len    (s1_len_r),
    .ctl         (ctl),
    .res         (res)
  );

  ncu_noise u_noise (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .noise_coef (noise_coef)
  );

  assign coef_nxt = res.noise_sel ? noise_coef : res.coef;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_coef_r       <= coef_nxt;
      out_coef_valid_r <= res.coef_valid;
      out_want_r       <= res.want_nibble;
      out_done_r       <= res.done;
      out_err_r        <= res.err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coefficient   = $signed(out_coef_r);
  assign out_coef_valid    = out_coef_valid_r;
  assign out_want_nibble   = out_want_r;
  assign out_subblock_done = out_done_r;
  assign out_error_flag    = out_err_r;

endmodule

`default_nettype wire

@@ hw/rtl/ncu_parser.sv @@
// ----------------------------------------------------------------------------
// ncu_parser: nibble stream parser
// Holds the parse phase, quantizer and coefficient/run counters, decodes one
// item per transfer and drives the noise unit with load and step commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ncu_parser
  import ncu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [1:0]       item_func,
  input  wire logic [3:0]       item_nibble,
  input  wire logic [LEN_W-1:0] item_len,
  output noise_ctl_t            ctl,
  output res_t                  res
);

  ph_t              phase_r, phase_nxt;
  logic [4:0]       quant_r, quant_nxt;
  logic [LEN_W-1:0] coefs_left_r, coefs_left_nxt;
  logic [LEN_W-1:0] run_left_r, run_left_nxt;
  kind_t            run_kind_r, run_kind_nxt;
  logic [7:0]       gathered_r, gathered_nxt;

  noise_ctl_t       ctl_c;
  logic [LEN_W-1:0] coefs_dec, run_dec;
  logic             run_go;
  kind_t            run_kind_sel;
  logic [LEN_W-1:0] run_len, run_clip;
  logic [2:0]       mag;
  logic [5:0]       mag_sq;
  logic [COEF_W-1:0] mag_scaled;
  logic [7:0]       nib_sq;
  logic [7:0]       decay_m;
  logic [15:0]      decay_m_sq;
  logic [8:0]       esc_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      quant_r      <= '0;
      coefs_left_r <= '0;
      run_left_r   <= '0;
      run_kind_r   <= KIND_NONE;
      gathered_r   <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      quant_r      <= quant_nxt;
      coefs_left_r <= coefs_left_nxt;
      run_left_r   <= run_left_nxt;
      run_kind_r   <= run_kind_nxt;
      gathered_r   <= gathered_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    quant_nxt      = quant_r;
    coefs_left_nxt = coefs_left_r;
    run_left_nxt   = run_left_r;
    run_kind_nxt   = run_kind_r;
    gathered_nxt   = gathered_r;
    res            = '0;
    ctl_c          = '0;
    ctl_c.quant    = quant_r;
    ctl_c.decay    = DECAY_ONE;
    run_go         = 1'b0;
    run_kind_sel   = KIND_ZERO;
    run_len        = '0;
    run_clip       = '0;

    coefs_dec  = (coefs_left_r != '0) ? coefs_left_r - LEN_W'(1) : '0;
    run_dec    = (run_left_r != '0) ? run_left_r - LEN_W'(1) : '0;
    mag        = item_nibble[3] ? 3'(~item_nibble + 4'd1) : item_nibble[2:0];
    mag_sq     = {3'b0, mag} * {3'b0, mag};
    mag_scaled = scaled(mag_sq, quant_r);
    nib_sq     = {4'b0, item_nibble} * {4'b0, item_nibble};
    decay_m    = {gathered_r[3:0], item_nibble};
    decay_m_sq = {8'b0, decay_m} * {8'b0, decay_m};
    esc_n      = {gathered_r, item_nibble[0]};

    if (item_func == FN_START) begin
      if (item_len == '0 || 32'(item_len) > MAX_SUBBLOCK) begin
        res.err = 1'b1;
      end else begin
        res.err        = (phase_r != PH_IDLE);
        phase_nxt      = PH_Q1;
        coefs_left_nxt = item_len;
        run_left_nxt   = '0;
        run_kind_nxt   = KIND_NONE;
      end
    end else if (item_func == FN_PULL) begin
      if (phase_r != PH_RUN) begin
        res.err = 1'b1;
      end else begin
        res.coef_valid = 1'b1;
        res.noise_sel  = (run_kind_r == KIND_NOISE);
        ctl_c.step     = (run_kind_r == KIND_NOISE);
        coefs_left_nxt = coefs_dec;
        run_left_nxt   = run_dec;
        if (coefs_dec == '0) begin
          res.done     = 1'b1;
          phase_nxt    = PH_IDLE;
          run_left_nxt = '0;
          run_kind_nxt = KIND_NONE;
        end else if (run_dec == '0) begin
          run_kind_nxt = KIND_NONE;
          phase_nxt    = PH_COEF;
        end
      end
    end else if (item_func != FN_NIBBLE || phase_r inside {PH_IDLE, PH_RUN}) begin
      res.err = 1'b1;
    end else begin
      case (phase_r)
        PH_Q1: begin
          if (item_nibble == NIB_FILL) begin
            // Noise fill cannot open a sub-block: drop it.
            res.err        = 1'b1;
            coefs_left_nxt = '0;
            phase_nxt      = PH_IDLE;
          end else if (item_nibble == NIB_ESC_Q) begin
            phase_nxt = PH_Q1E;
          end else begin
            quant_nxt = {1'b0, item_nibble};
            phase_nxt = PH_COEF;
          end
        end
        PH_Q1E, PH_QCE: begin
          if (item_nibble == NIB_FILL) begin
            run_go  = 1'b1;
            run_len = coefs_left_r;
          end else begin
            if (item_nibble > NIB_EXT_MAX) begin
              res.err = 1'b1;
            end else begin
              quant_nxt = 5'd14 + {1'b0, item_nibble};
            end
            phase_nxt = PH_COEF;
          end
        end
        PH_COEF: begin
          if (item_nibble == NIB_ESC_Z) begin
            phase_nxt = PH_Z1;
          end else if (item_nibble == NIB_ESC_RUN) begin
            phase_nxt = PH_E1;
          end else begin
            res.coef       = item_nibble[3] ? COEF_W'(-mag_scaled) : mag_scaled;
            res.coef_valid = 1'b1;
            coefs_left_nxt = coefs_dec;
            if (coefs_dec == '0) begin
              res.done     = 1'b1;
              phase_nxt    = PH_IDLE;
              run_left_nxt = '0;
              run_kind_nxt = KIND_NONE;
            end
          end
        end
        PH_Z1: begin
          gathered_nxt = {4'b0, item_nibble};
          phase_nxt    = PH_Z2;
        end
        PH_Z2: begin
          gathered_nxt = {gathered_r[3:0], item_nibble};
          phase_nxt    = PH_Z3;
        end
        PH_Z3: begin
          run_go = 1'b1;
          if (item_nibble[3:1] != 3'd0) begin
            run_kind_sel   = KIND_NOISE;
            run_len        = LEN_W'(esc_n) + LEN_W'(16);
            ctl_c.load_amp   = 1'b1;
            ctl_c.amp_mult   = {3'b0, item_nibble[3:1]};
            ctl_c.load_decay = 1'b1;
          end else begin
            run_len = LEN_W'(esc_n) + LEN_W'(31);
          end
        end
        PH_E1: begin
          if (item_nibble != 4'd0) begin
            run_go  = 1'b1;
            run_len = LEN_W'(item_nibble);
          end else begin
            phase_nxt = PH_QC;
          end
        end
        PH_QC: begin
          if (item_nibble == NIB_FILL) begin
            phase_nxt = PH_NFV;
          end else if (item_nibble == NIB_ESC_Q) begin
            phase_nxt = PH_QCE;
          end else begin
            quant_nxt = {1'b0, item_nibble};
            phase_nxt = PH_COEF;
          end
        end
        PH_NFV: begin
          ctl_c.load_amp = 1'b1;
          ctl_c.amp_mult = 6'd1 + {3'b0, item_nibble[3:1]};
          phase_nxt      = item_nibble[0] ? PH_NFH : PH_NFS;
        end
        PH_NFS: begin
          ctl_c.load_decay = 1'b1;
          ctl_c.decay      = DECAY_ONE - {9'b0, nib_sq};
          run_left_nxt     = coefs_left_r;
          run_kind_nxt     = KIND_NOISE;
          phase_nxt        = PH_RUN;
        end
        PH_NFH: begin
          gathered_nxt = {4'b0, item_nibble};
          phase_nxt    = PH_NFL;
        end
        PH_NFL: begin
          ctl_c.load_decay = 1'b1;
          ctl_c.decay      = DECAY_ONE - {1'b0, decay_m_sq};
          run_left_nxt     = coefs_left_r;
          run_kind_nxt     = KIND_NOISE;
          phase_nxt        = PH_RUN;
        end
        default: begin
          res.err = 1'b1;
        end
      endcase
    end

    // A run never extends past the end of the sub-block.
    if (run_go) begin
      run_clip     = (run_len > coefs_left_r) ? coefs_left_r : run_len;
      run_left_nxt = run_clip;
      run_kind_nxt = run_kind_sel;
      phase_nxt    = (run_clip != '0) ? PH_RUN : PH_IDLE;
    end

    res.want_nibble = !(phase_nxt inside {PH_IDLE, PH_RUN});

    ctl            = ctl_c;
    ctl.step       = ctl_c.step & fire;
    ctl.load_amp   = ctl_c.load_amp & fire;
    ctl.load_decay = ctl_c.load_decay & fire;
  end

endmodule

`default_nettype wire

@@ hw/rtl/ncu_noise.sv @@
// ----------------------------------------------------------------------------
// ncu_noise: noise generator
// Xorshift32 seed, noise amplitude and decay factor. Gives the scaled noise
// coefficient for the current amplitude and applies the decay on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module ncu_noise
  import ncu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  noise_ctl_t        ctl,
  output logic [COEF_W-1:0] noise_coef
);

  logic [31:0]        seed_r;
  logic [COEF_W-1:0]  amp_r;
  logic [DECAY_W-1:0] decay_r;

  logic [31:0]         x1, x2, x3;
  logic signed [72:0]  noise_prod;
  logic [56:0]         decay_prod;

  always_comb begin
    x1 = seed_r ^ (seed_r << 13);
    x2 = x1 ^ (x1 >> 17);
    x3 = x2 ^ (x2 << 5);
    // amp * s / 2^31 with floor: the arithmetic shift is a bit-select.
    noise_prod = $signed({33'b0, amp_r}) * $signed({{41{x3[31]}}, x3});
    decay_prod = {17'b0, amp_r} * {40'b0, decay_r};
    noise_coef = noise_prod[70:31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= NOISE_SEED_INIT;
      amp_r   <= '0;
      decay_r <= DECAY_ONE;
    end else begin
      if (ctl.step) begin
        seed_r <= x3;
        amp_r  <= decay_prod[55:16];
      end else if (ctl.load_amp) begin
        amp_r <= scaled(ctl.amp_mult, ctl.quant);
      end
      if (ctl.load_decay) begin
        decay_r <= ctl.decay;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ncu_checker.sv @@
// ----------------------------------------------------------------------------
// ncu_checker: port-level checks of the nibble coefficient unpacker
// Watches the top-level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module ncu_checker
  import ncu_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [COEF_W-1:0] out_coefficient,
  input wire logic              out_coef_valid,
  input wire logic              out_want_nibble,
  input wire logic              out_subblock_done,
  input wire logic              out_error_flag
);

  // A stalled result is held until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coefficient) &&
      $stable(out_coef_valid) && $stable(out_subblock_done))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Results without a coefficient carry zero.
  a_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_coef_valid |-> out_coefficient == '0)
    else $error("nonzero coefficient without coef_valid");

  // The last coefficient closes the sub-block: nothing more is wanted.
  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_subblock_done |-> out_coef_valid && !out_want_nibble)
    else $error("subblock_done without a closing coefficient");

  // An item in error never produces a coefficient.
  a_err_no_coef: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> !out_coef_valid && !out_subblock_done)
    else $error("coefficient emitted on an error result");

endmodule

bind nibble_coefficient_unpacker ncu_checker u_ncu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_coefficient   (out_coefficient),
  .out_coef_valid    (out_coef_valid),
  .out_want_nibble   (out_want_nibble),
  .out_subblock_done (out_subblock_done),
  .out_error_flag    (out_error_flag)
);

`default_nettype wire
